>>> rtl/hrf_pkg.sv
`timescale 1ns / 1ps
package hrf_pkg;

	localparam int LenBits = 32;
	localparam int OutLenBits = 32;
	localparam int TeLen = 17;
	localparam int ClLen = 14;
	localparam int PosBits = 5;

	localparam logic [8*TeLen-1:0] TeText = "transfer-encoding";
	localparam logic [8*ClLen-1:0] ClText = "content-length";

	localparam logic [7:0] ChCr = 8'h0d;
	localparam logic [7:0] ChLf = 8'h0a;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChColon = 8'h3a;

	typedef logic [LenBits-1:0] len_t;

	typedef enum logic [3:0] {
		PH_STATUS,
		PH_LINE_START,
		PH_NAME,
		PH_VALUE,
		PH_CHUNK_SIZE,
		PH_CHUNK_DATA,
		PH_CHUNK_TAIL,
		PH_FIXED,
		PH_CLOSE,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		MODE_CLOSE = 2'd0,
		MODE_CHUNK = 2'd1,
		MODE_FIXED = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		K_STATUS = 3'd0,
		K_NAME   = 3'd1,
		K_VALUE  = 3'd2,
		K_BODY   = 3'd3,
		K_FRAME  = 3'd4,
		K_END    = 3'd5
	} kind_t;

	typedef struct packed {
		logic [7:0]            data;
		kind_t                 kind;
		logic                  done;
		mode_t                 mode;
		logic [OutLenBits-1:0] length;
	} result_t;

	function automatic logic [7:0] te_char(logic [PosBits-1:0] pos);
		if (int'(pos) < TeLen)
			return TeText[8*(TeLen-1-int'(pos)) +: 8];
		return 8'h00;
	endfunction

	function automatic logic [7:0] cl_char(logic [PosBits-1:0] pos);
		if (int'(pos) < ClLen)
			return ClText[8*(ClLen-1-int'(pos)) +: 8];
		return 8'h00;
	endfunction

	function automatic len_t sat_mul10_add(len_t acc, logic [3:0] d);
		logic [LenBits+3:0] w;
		w = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (LenBits+4)'(d);
		if (w[LenBits+3:LenBits] != 4'b0)
			return '1;
		return w[LenBits-1:0];
	endfunction

	function automatic len_t sat_mul16_add(len_t acc, logic [3:0] d);
		if (acc[LenBits-1 -: 4] != 4'b0)
			return '1;
		return {acc[LenBits-5:0], d};
	endfunction

	function automatic len_t sat_add(len_t a, len_t b);
		logic [LenBits:0] w;
		w = {1'b0, a} + {1'b0, b};
		if (w[LenBits])
			return '1;
		return w[LenBits-1:0];
	endfunction

	function automatic logic [OutLenBits-1:0] clip_len(len_t v);
		logic [63:0] w;
		logic [63:0] lim;
		w = 64'(v);
		lim = {{(64-OutLenBits){1'b0}}, {OutLenBits{1'b1}}};
		if (w > lim)
			return '1;
		return w[OutLenBits-1:0];
	endfunction

endpackage

>>> rtl/hrf_core.sv
`timescale 1ns / 1ps
module hrf_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      data_byte,
	input  logic            restart,
	output hrf_pkg::result_t result
);
	import hrf_pkg::*;

	phase_t             phase_q, cur_phase, n_phase;
	logic               prev_cr_q, cur_prev_cr;
	logic [PosBits-1:0] pos_q, cur_pos, n_pos;
	logic               te_q, cur_te, n_te;
	logic               cl_q, cur_cl, n_cl;
	logic               started_q, cur_started, n_started;
	logic               closed_q, cur_closed, n_closed;
	len_t               acc_q, cur_acc, n_acc;
	len_t               rem_q, cur_rem, n_rem;
	mode_t              mode_q, cur_mode, n_mode;
	len_t               total_q, cur_total, n_total;

	logic       cr, eol, is_digit, is_hex;
	logic [7:0] lc;
	logic [3:0] digit, hex;
	len_t       rem_dec;
	kind_t      kind;
	logic       done;

	always_comb begin
		if (restart) begin
			cur_phase   = PH_STATUS;
			cur_prev_cr = 1'b0;
			cur_pos     = '0;
			cur_te      = 1'b1;
			cur_cl      = 1'b1;
			cur_started = 1'b0;
			cur_closed  = 1'b0;
			cur_acc     = '0;
			cur_rem     = '0;
			cur_mode    = MODE_CLOSE;
			cur_total   = '0;
		end else begin
			cur_phase   = phase_q;
			cur_prev_cr = prev_cr_q;
			cur_pos     = pos_q;
			cur_te      = te_q;
			cur_cl      = cl_q;
			cur_started = started_q;
			cur_closed  = closed_q;
			cur_acc     = acc_q;
			cur_rem     = rem_q;
			cur_mode    = mode_q;
			cur_total   = total_q;
		end
	end

	always_comb begin
		cr       = (data_byte == ChCr);
		eol      = (data_byte == ChLf) && cur_prev_cr;
		lc       = (data_byte >= "A" && data_byte <= "Z") ? data_byte + 8'd32 : data_byte;
		is_digit = (data_byte >= "0" && data_byte <= "9");
		digit    = 4'(data_byte - "0");
		is_hex   = 1'b1;
		hex      = digit;
		if (is_digit)
			hex = digit;
		else if (data_byte >= "a" && data_byte <= "f")
			hex = 4'(data_byte - "a" + 8'd10);
		else if (data_byte >= "A" && data_byte <= "F")
			hex = 4'(data_byte - "A" + 8'd10);
		else
			is_hex = 1'b0;
		rem_dec = (cur_rem != '0) ? cur_rem - len_t'(1) : '0;
	end

	// next state
	always_comb begin
		n_phase   = cur_phase;
		n_pos     = cur_pos;
		n_te      = cur_te;
		n_cl      = cur_cl;
		n_started = cur_started;
		n_closed  = cur_closed;
		n_acc     = cur_acc;
		n_rem     = cur_rem;
		n_mode    = cur_mode;
		n_total   = cur_total;
		unique case (cur_phase)
			PH_STATUS: begin
				if (eol) begin
					n_phase   = PH_LINE_START;
					n_pos     = '0;
					n_te      = 1'b1;
					n_cl      = 1'b1;
					n_started = 1'b0;
					n_closed  = 1'b0;
					n_acc     = '0;
				end
			end
			PH_LINE_START, PH_NAME: begin
				if (cr) begin
				end else if (eol) begin
					if (cur_phase == PH_NAME) begin
						n_phase   = PH_LINE_START;
						n_pos     = '0;
						n_te      = 1'b1;
						n_cl      = 1'b1;
						n_started = 1'b0;
						n_closed  = 1'b0;
						n_acc     = '0;
					end else if (cur_mode == MODE_CHUNK) begin
						n_phase  = PH_CHUNK_SIZE;
						n_acc    = '0;
						n_closed = 1'b0;
					end else if (cur_mode == MODE_FIXED) begin
						n_rem   = cur_total;
						n_phase = (cur_total == '0) ? PH_DONE : PH_FIXED;
					end else begin
						n_phase = PH_CLOSE;
					end
				end else if (data_byte == ChColon) begin
					n_phase = PH_VALUE;
					if (cur_phase == PH_NAME) begin
						n_te = cur_te && (int'(cur_pos) == TeLen);
						n_cl = cur_cl && (int'(cur_pos) == ClLen);
					end else begin
						n_te = 1'b0;
						n_cl = 1'b0;
					end
				end else begin
					n_phase = PH_NAME;
					if (data_byte != ChSpace) begin
						if (te_char(cur_pos) != lc || int'(cur_pos) >= TeLen)
							n_te = 1'b0;
						if (cl_char(cur_pos) != lc || int'(cur_pos) >= ClLen)
							n_cl = 1'b0;
						if (cur_pos != '1)
							n_pos = cur_pos + PosBits'(1);
					end
				end
			end
			PH_VALUE: begin
				if (cr) begin
				end else if (eol) begin
					if (cur_te)
						n_mode = MODE_CHUNK;
					if (cur_cl) begin
						n_mode  = MODE_FIXED;
						n_total = cur_acc;
					end
					n_phase   = PH_LINE_START;
					n_pos     = '0;
					n_te      = 1'b1;
					n_cl      = 1'b1;
					n_started = 1'b0;
					n_closed  = 1'b0;
					n_acc     = '0;
				end else if (data_byte == ChSpace && !cur_started) begin
				end else begin
					n_started = 1'b1;
					if (!cur_closed) begin
						if (is_digit)
							n_acc = sat_mul10_add(cur_acc, digit);
						else
							n_closed = 1'b1;
					end
				end
			end
			PH_CHUNK_SIZE: begin
				if (eol) begin
					if (cur_acc == '0) begin
						n_phase = PH_DONE;
					end else begin
						n_rem   = cur_acc;
						n_total = sat_add(cur_total, cur_acc);
						n_phase = PH_CHUNK_DATA;
					end
				end else if (!cr && !cur_closed) begin
					if (is_hex)
						n_acc = sat_mul16_add(cur_acc, hex);
					else
						n_closed = 1'b1;
				end
			end
			PH_CHUNK_DATA: begin
				n_rem = rem_dec;
				if (rem_dec == '0) begin
					n_phase = PH_CHUNK_TAIL;
					n_rem   = len_t'(2);
				end
			end
			PH_CHUNK_TAIL: begin
				n_rem = rem_dec;
				if (rem_dec == '0) begin
					n_phase  = PH_CHUNK_SIZE;
					n_acc    = '0;
					n_closed = 1'b0;
				end
			end
			PH_FIXED: begin
				n_rem = rem_dec;
				if (rem_dec == '0)
					n_phase = PH_DONE;
			end
			PH_CLOSE: begin
				n_total = sat_add(cur_total, len_t'(1));
			end
			default: begin
				n_phase = PH_DONE;
			end
		endcase
	end

	// outputs
	always_comb begin
		kind = K_FRAME;
		done = 1'b0;
		unique case (cur_phase)
			PH_STATUS: begin
				kind = (cr || eol) ? K_FRAME : K_STATUS;
			end
			PH_LINE_START, PH_NAME: begin
				if (cr || eol || data_byte == ChColon)
					kind = K_FRAME;
				else
					kind = K_NAME;
				if (cur_phase == PH_LINE_START && eol && cur_mode == MODE_FIXED
						&& cur_total == '0)
					done = 1'b1;
			end
			PH_VALUE: begin
				if (cr || eol || (data_byte == ChSpace && !cur_started))
					kind = K_FRAME;
				else
					kind = K_VALUE;
			end
			PH_CHUNK_SIZE: begin
				kind = K_FRAME;
				done = eol && (cur_acc == '0);
			end
			PH_CHUNK_DATA: kind = K_BODY;
			PH_CHUNK_TAIL: kind = K_FRAME;
			PH_FIXED: begin
				kind = K_BODY;
				done = (rem_dec == '0);
			end
			PH_CLOSE: kind = K_BODY;
			default: kind = K_END;
		endcase
	end

	always_comb begin
		result.data   = data_byte;
		result.kind   = kind;
		result.done   = done;
		result.mode   = n_mode;
		result.length = clip_len(n_total);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_STATUS;
			prev_cr_q <= 1'b0;
			pos_q     <= '0;
			te_q      <= 1'b1;
			cl_q      <= 1'b1;
			started_q <= 1'b0;
			closed_q  <= 1'b0;
			acc_q     <= '0;
			rem_q     <= '0;
			mode_q    <= MODE_CLOSE;
			total_q   <= '0;
		end else if (accept) begin
			phase_q   <= n_phase;
			prev_cr_q <= cr;
			pos_q     <= n_pos;
			te_q      <= n_te;
			cl_q      <= n_cl;
			started_q <= n_started;
			closed_q  <= n_closed;
			acc_q     <= n_acc;
			rem_q     <= n_rem;
			mode_q    <= n_mode;
			total_q   <= n_total;
		end
	end

endmodule

>>> rtl/http_response_framer_top.sv
`timescale 1ns / 1ps
// channel  | handshake          | payload
// ---------+--------------------+----------------------------------------------
// in       | in_valid, in_stall | data_byte[7:0], restart
// out      | out_valid,out_stall| out_byte[7:0], byte_kind[2:0], message_done,
//          |                    | transfer_mode[1:0], body_length[31:0]
//
// One request per cycle while in_stall is low; results are registered.
// All parser state updates in the cycle of acceptance; a two-entry output
// (result register plus skid register) decouples the channels.
// in_stall rises only when both output entries are full.
// arst_n clears parser state to the status-line phase and empties the output.
module http_response_framer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [2:0]  byte_kind,
	output logic        message_done,
	output logic [1:0]  transfer_mode,
	output logic [31:0] body_length
);
	import hrf_pkg::*;

	logic    accept, take;
	result_t res;
	result_t main_q, skid_q;
	logic    main_valid_q, skid_valid_q;

	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;
	assign take     = main_valid_q && !out_stall;

	hrf_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.restart   (restart),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || take) begin
			main_valid_q <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || take) begin
			if (skid_valid_q)
				main_q <= skid_q;
			else if (accept)
				main_q <= res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign out_valid     = main_valid_q;
	assign out_byte      = main_q.data;
	assign byte_kind     = main_q.kind;
	assign message_done  = main_q.done;
	assign transfer_mode = main_q.mode;
	assign body_length   = main_q.length;

endmodule

>>> sim/tb_http_response_framer_top.sv
`timescale 1ns / 1ps
module tb_http_response_framer_top;
	import hrf_pkg::*;

	localparam int CycleLimit = 400000;

	localparam int HdrTe = 0;
	localparam int HdrCl = 1;
	localparam int HdrOther = 2;
	localparam int HdrNoColon = 3;
	localparam int HdrBareColon = 4;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        restart;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic [2:0]  byte_kind;
	logic        message_done;
	logic [1:0]  transfer_mode;
	logic [31:0] body_length;

	result_t pending_tags[$];
	int      err_cnt = 0;
	int      bytes_sent = 0;
	int      cycle_cnt = 0;
	int      in_gap_max = 17;
	int      out_gap_max = 17;
	int      hold_len = 0;

	// parser state mirrored for tag prediction
	phase_t         ph;
	logic           cr_prev;
	logic [PosBits-1:0] name_pos;
	logic           te_ok;
	logic           cl_ok;
	logic           val_started;
	logic           digits_done;
	len_t           num_acc;
	len_t           remain;
	mode_t          mode;
	len_t           total;
	string          te_word = "transfer-encoding";
	string          cl_word = "content-length";

	http_response_framer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.restart       (restart),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.byte_kind     (byte_kind),
		.message_done  (message_done),
		.transfer_mode (transfer_mode),
		.body_length   (body_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic void clear_line();
		name_pos = '0;
		te_ok = 1'b1;
		cl_ok = 1'b1;
		val_started = 1'b0;
		digits_done = 1'b0;
		num_acc = '0;
	endfunction

	function automatic void reset_parser();
		ph = PH_STATUS;
		cr_prev = 1'b0;
		clear_line();
		remain = '0;
		mode = MODE_CLOSE;
		total = '0;
	endfunction

	function automatic len_t grow_num(len_t acc, int base, int digit);
		logic [LenBits+5:0] w;
		w = (LenBits+6)'(acc) * (LenBits+6)'(base) + (LenBits+6)'(digit);
		if (w[LenBits+5:LenBits] != '0)
			return '1;
		return w[LenBits-1:0];
	endfunction

	function automatic len_t add_clip(len_t a, len_t b);
		logic [LenBits:0] w;
		w = {1'b0, a} + {1'b0, b};
		if (w[LenBits])
			return '1;
		return w[LenBits-1:0];
	endfunction

	function automatic void match_name(logic [7:0] b);
		logic [7:0] lc;
		if (b == ChSpace)
			return;
		lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
		if (!(name_pos < TeLen && te_word[name_pos] == lc))
			te_ok = 1'b0;
		if (!(name_pos < ClLen && cl_word[name_pos] == lc))
			cl_ok = 1'b0;
		if (name_pos < 31)
			name_pos++;
	endfunction

	function automatic result_t frame_byte(logic [7:0] b, logic rs);
		result_t r;
		kind_t   k;
		logic    fin;
		logic    is_cr;
		logic    is_eol;
		int      hv;
		k = K_FRAME;
		fin = 1'b0;
		hv = -1;
		if (rs)
			reset_parser();
		is_cr = (b == ChCr);
		is_eol = (b == ChLf) && cr_prev;
		case (ph)
		PH_STATUS: begin
			if (is_eol) begin
				ph = PH_LINE_START;
				clear_line();
			end else if (!is_cr) begin
				k = K_STATUS;
			end
		end
		PH_LINE_START: begin
			if (is_eol) begin
				if (mode == MODE_CHUNK) begin
					ph = PH_CHUNK_SIZE;
					num_acc = '0;
					digits_done = 1'b0;
				end else if (mode == MODE_FIXED) begin
					remain = total;
					if (remain == '0) begin
						ph = PH_DONE;
						fin = 1'b1;
					end else begin
						ph = PH_FIXED;
					end
				end else begin
					ph = PH_CLOSE;
				end
			end else if (b == ChColon) begin
				te_ok = 1'b0;
				cl_ok = 1'b0;
				ph = PH_VALUE;
			end else if (!is_cr) begin
				k = K_NAME;
				match_name(b);
				ph = PH_NAME;
			end
		end
		PH_NAME: begin
			if (is_eol) begin
				ph = PH_LINE_START;
				clear_line();
			end else if (b == ChColon) begin
				te_ok = te_ok && (name_pos == TeLen);
				cl_ok = cl_ok && (name_pos == ClLen);
				ph = PH_VALUE;
			end else if (!is_cr) begin
				k = K_NAME;
				match_name(b);
			end
		end
		PH_VALUE: begin
			if (is_eol) begin
				if (te_ok)
					mode = MODE_CHUNK;
				if (cl_ok) begin
					mode = MODE_FIXED;
					total = num_acc;
				end
				ph = PH_LINE_START;
				clear_line();
			end else if (!is_cr && !(b == ChSpace && !val_started)) begin
				k = K_VALUE;
				val_started = 1'b1;
				if (!digits_done) begin
					if (b >= "0" && b <= "9")
						num_acc = grow_num(num_acc, 10, int'(b - "0"));
					else
						digits_done = 1'b1;
				end
			end
		end
		PH_CHUNK_SIZE: begin
			if (is_eol) begin
				if (num_acc == '0) begin
					ph = PH_DONE;
					fin = 1'b1;
				end else begin
					remain = num_acc;
					total = add_clip(total, num_acc);
					ph = PH_CHUNK_DATA;
				end
			end else if (!is_cr && !digits_done) begin
				if (b >= "0" && b <= "9")
					hv = int'(b - "0");
				else if (b >= "a" && b <= "f")
					hv = int'(b - "a") + 10;
				else if (b >= "A" && b <= "F")
					hv = int'(b - "A") + 10;
				if (hv >= 0)
					num_acc = grow_num(num_acc, 16, hv);
				else
					digits_done = 1'b1;
			end
		end
		PH_CHUNK_DATA: begin
			k = K_BODY;
			if (remain != '0)
				remain--;
			if (remain == '0) begin
				ph = PH_CHUNK_TAIL;
				remain = len_t'(2);
			end
		end
		PH_CHUNK_TAIL: begin
			if (remain != '0)
				remain--;
			if (remain == '0) begin
				ph = PH_CHUNK_SIZE;
				num_acc = '0;
				digits_done = 1'b0;
			end
		end
		PH_FIXED: begin
			k = K_BODY;
			if (remain != '0)
				remain--;
			if (remain == '0) begin
				ph = PH_DONE;
				fin = 1'b1;
			end
		end
		PH_CLOSE: begin
			k = K_BODY;
			total = add_clip(total, len_t'(1));
		end
		default: begin
			k = K_END;
			ph = PH_DONE;
		end
		endcase
		cr_prev = is_cr;
		r.data = b;
		r.kind = k;
		r.done = fin;
		r.mode = mode;
		r.length = (LenBits > OutLenBits && (total >> OutLenBits) != 0) ? '1 : OutLenBits'(total);
		return r;
	endfunction

	function automatic int draw_wait(int maxw);
		if (maxw == 0 || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, maxw);
	endfunction

	function automatic void pick_idling();
		in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
		out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
	endfunction

	function automatic string mix_case(string s, int space_odds);
		string o;
		logic [7:0] c;
		o = "";
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
				c = c - 8'd32;
			if (space_odds > 0 && $urandom_range(0, space_odds - 1) == 0)
				o = {o, " "};
			o = $sformatf("%s%c", o, c);
		end
		return o;
	endfunction

	function automatic void cmp_field(string fname, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
			err_cnt++;
		end
	endfunction

	task automatic send_req(input logic [7:0] b, input logic rs);
		int w;
		w = draw_wait(in_gap_max);
		if (w > 0) begin
			in_valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		restart <= rs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_tags.insert(pending_tags.size(), frame_byte(b, rs));
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_req(s[i], 1'b0);
	endtask

	task automatic send_random_bytes(input int n, input bit printable);
		for (int i = 0; i < n; i++)
			send_req(printable ? 8'($urandom_range(33, 126)) : 8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_tags.size() != 0) @(posedge clk);
	endtask

	task automatic send_header(input int hdr);
		string txt;
		case (hdr)
		HdrTe: begin
			send_text(mix_case("transfer-encoding", 10));
			send_req(ChColon, 1'b0);
			repeat ($urandom_range(0, 2)) send_req(ChSpace, 1'b0);
			send_text(mix_case("chunked", 0));
		end
		HdrCl: begin
			send_text(mix_case("content-length", 10));
			send_req(ChColon, 1'b0);
			repeat ($urandom_range(0, 2)) send_req(ChSpace, 1'b0);
			case ($urandom_range(0, 9))
			0: txt = "98765432109876543";
			1: txt = "+7";
			default: txt = $sformatf("%0d", $urandom_range(0, 30));
			endcase
			if ($urandom_range(0, 4) == 0)
				txt = {txt, " 9x"};
			send_text(txt);
		end
		HdrOther: begin
			case ($urandom_range(0, 5))
			0: txt = "content-type";
			1: txt = "content-lengthx";
			2: txt = "transfer-encodin";
			3: txt = "server";
			4: txt = "x-very-long-header-name-beyond-limit";
			default: txt = "te";
			endcase
			send_text(mix_case(txt, 8));
			send_req(ChColon, 1'b0);
			repeat ($urandom_range(0, 2)) send_req(ChSpace, 1'b0);
			send_random_bytes($urandom_range(0, 6), 1'b1);
		end
		HdrNoColon: send_text(mix_case("no colon here", 0));
		default: send_text(": v 12");
		endcase
		send_text("\r\n");
	endtask

	task automatic send_message(input mode_t want, input bit mixed);
		int    n;
		logic  rs;
		string txt;
		rs = ($urandom_range(0, 5) != 0);
		n = $urandom_range(0, 6);
		for (int i = 0; i < n; i++)
			send_req(8'($urandom_range(0, 255)), rs && i == 0);
		send_req(ChCr, rs && n == 0);
		send_req(ChLf, 1'b0);
		n = $urandom_range(0, mixed ? 4 : 2);
		for (int i = 0; i < n; i++)
			send_header(mixed ? $urandom_range(HdrTe, HdrBareColon)
			                  : $urandom_range(HdrOther, HdrBareColon));
		if (!mixed && want == MODE_CHUNK)
			send_header(HdrTe);
		if (!mixed && want == MODE_FIXED)
			send_header(HdrCl);
		if ($urandom_range(0, 3) == 0)
			send_header(mixed ? $urandom_range(HdrTe, HdrBareColon) : HdrOther);
		send_text("\r\n");
		if (ph == PH_FIXED) begin
			send_random_bytes((remain > 40) ? 40 : int'(remain), 1'b0);
		end else if (ph == PH_CLOSE) begin
			send_random_bytes($urandom_range(0, 15), 1'b0);
		end else if (ph == PH_CHUNK_SIZE) begin
			n = $urandom_range(0, 3);
			for (int c = 0; c < n; c++) begin
				if ($urandom_range(0, 9) == 0)
					txt = "fffffffff";
				else
					txt = $sformatf("%0h", $urandom_range(1, 12));
				if ($urandom_range(0, 3) == 0)
					txt = {"00", txt};
				txt = mix_case(txt, 0);
				if ($urandom_range(0, 3) == 0)
					txt = {txt, ";ext=1"};
				send_text({txt, "\r\n"});
				send_random_bytes((remain > 20) ? 20 : int'(remain), 1'b0);
				// drop the rest of an oversized chunk
				if (ph != PH_CHUNK_TAIL)
					return;
				if ($urandom_range(0, 3) != 0)
					send_text("\r\n");
				else
					send_random_bytes(2, 1'b0);
			end
			case ($urandom_range(0, 3))
			0: send_text("0\r\n");
			1: send_text("000;x\r\n");
			2: send_text("\r\n");
			default: send_text("zz\r\n");
			endcase
		end
		if ($urandom_range(0, 2) == 0)
			send_random_bytes($urandom_range(1, 3), 1'b0);
	endtask

	task automatic test_empty_fixed_body();
		send_req(8'hff, 1'b1);
		send_req(8'h00, 1'b0);
		send_req(ChLf, 1'b0);
		send_text("\r\n");
		send_text("Content-Length:0\r\n\r\n");
		send_req(8'hff, 1'b0);
	endtask

	task automatic test_output_backpressure();
		wait_drained();
		in_gap_max = 0;
		out_gap_max = 0;
		// hold the output so the input side backs up
		hold_len = 80;
		send_message(MODE_FIXED, 1'b0);
		send_message(MODE_CHUNK, 1'b0);
		wait_drained();
	endtask

	task automatic test_chunked_bodies();
		int upto;
		upto = bytes_sent + 350;
		while (bytes_sent < upto) begin
			pick_idling();
			send_message(MODE_CHUNK, 1'b0);
		end
	endtask

	task automatic test_fixed_bodies();
		int upto;
		upto = bytes_sent + 330;
		while (bytes_sent < upto) begin
			pick_idling();
			send_message(MODE_FIXED, 1'b0);
		end
	endtask

	task automatic test_close_bodies();
		int upto;
		upto = bytes_sent + 200;
		while (bytes_sent < upto) begin
			pick_idling();
			send_message(MODE_CLOSE, 1'b0);
		end
	endtask

	task automatic test_mixed_traffic();
		int upto;
		int n;
		upto = bytes_sent + 420;
		while (bytes_sent < upto) begin
			pick_idling();
			if ($urandom_range(0, 7) == 0)
				wait_drained();
			if ($urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					send_req(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end
			send_message(MODE_CLOSE, 1'b1);
		end
	endtask

	initial begin : result_sink
		result_t exp_tag;
		int      w;
		out_stall <= 1'b1;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_len > 0) begin
				w = hold_len;
				hold_len = 0;
			end else begin
				w = draw_wait(out_gap_max);
			end
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (pending_tags.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual byte %0h",
				         $time, out_byte);
				err_cnt++;
			end else begin
				exp_tag = pending_tags.pop_front();
				cmp_field("out_byte", 32'(exp_tag.data), 32'(out_byte));
				cmp_field("byte_kind", 32'(exp_tag.kind), 32'(byte_kind));
				cmp_field("message_done", 32'(exp_tag.done), 32'(message_done));
				cmp_field("transfer_mode", 32'(exp_tag.mode), 32'(transfer_mode));
				cmp_field("body_length", 32'(exp_tag.length), 32'(body_length));
			end
		end
	end

	initial begin
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		restart <= 1'b0;
		arst_n <= 1'b0;
		reset_parser();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_fixed_body();
		test_output_backpressure();
		test_chunked_bodies();
		test_fixed_bodies();
		test_close_bodies();
		test_mixed_traffic();
		wait_drained();
		repeat (8) @(posedge clk);
		if (err_cnt == 0 && pending_tags.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/hrf_pkg.sv
rtl/hrf_core.sv
rtl/http_response_framer_top.sv
sim/tb_http_response_framer_top.sv
